// File: src/mldq_pkg.sv
// shared constants, types and helpers of the multi-level descriptor queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mldq_pkg;

  // pool and buffer sizing; the allocation alignment is a power of two
  localparam int DESC_COUNT   = 16;
  localparam int BUFFER_BYTES = 2048;
  localparam int ALLOC_ALIGN  = 8;
  localparam int LEVELS       = 4;

  localparam int IDX_W    = $clog2(DESC_COUNT);
  localparam int LINK_W   = $clog2(DESC_COUNT + 1);
  localparam int FILL_W   = $clog2(BUFFER_BYTES + 1);

  // transaction field widths
  localparam int KIND_W   = 3;
  localparam int LVL_W    = 2;
  localparam int LEN_W    = 12;
  localparam int REF_W    = 4;
  localparam int STATUS_W = 2;
  localparam int EIDX_W   = 4;
  localparam int OFS_W    = 11;
  localparam int SOFS_W   = 32;

  localparam int SUM_W    = $clog2(BUFFER_BYTES + (1 << LEN_W) + ALLOC_ALIGN);

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = STATUS_W + 1;
  localparam int IN_PAD_W    = IN_TDATA_W - (LVL_W + LEN_W + REF_W);
  localparam int OUT_PAD_W   = OUT_TDATA_W - (EIDX_W + LVL_W + OFS_W + LEN_W + SOFS_W);

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(DESC_COUNT);

  localparam logic [KIND_W-1:0] K_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] K_PEEK   = 3'd1;
  localparam logic [KIND_W-1:0] K_FOLLOW = 3'd2;
  localparam logic [KIND_W-1:0] K_POP    = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_DESC   = 2'd2,
    ST_NO_SPACE  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FOLLOW,
    S_LINK
  } state_e;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [OFS_W-1:0]  pos;
    logic [LEN_W-1:0]  length;
    logic [SOFS_W-1:0] stream;
  } desc_t;

  typedef struct packed {
    logic              re;
    logic [IDX_W-1:0]  raddr;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
  } link_req_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    desc_t            wdata;
  } desc_req_t;

  // after reset entry i links i+1 and the last one links null
  function automatic logic [LINK_W-1:0] link_reset(input logic [IDX_W-1:0] idx);
    return LINK_W'(idx) + LINK_W'(1);
  endfunction

  function automatic logic is_link(input logic [LINK_W-1:0] lnk);
    return lnk < LINK_NULL;
  endfunction

endpackage

`default_nettype wire

// File: src/multi_level_descriptor_queue_core.sv
// descriptor queue top: sequencer, free list, buffer fill and per-level queues
// uses mldq_pkg, mldq_link_mem and mldq_desc_mem
//
//   channel   | dir | handshake                    | payload
//   s_axis    | in  | s_axis_tvalid_i / _tready_o  | tuser kind, tdata level, length, ref
//   m_axis    | out | m_axis_tvalid_o / _tready_i  | tuser status, found; tdata descriptor
//
// one transaction at a time; a follow of a link to a live entry passes EXEC then FOLLOW,
// an accepted append to a non-empty level EXEC then LINK, any other transaction EXEC alone; EXEC
// and FOLLOW wait for a free result register; the registered memory reads set this
// reset is ready at once: link table entries carry valid bits, no clearing pass
// the result register lets the next transaction in while a result waits
`timescale 1ns / 1ps
`default_nettype none

module multi_level_descriptor_queue_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // level[1:0], record_length[13:2], entry_ref[17:14], zero pad
  input  wire logic [mldq_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // kind[2:0]
  input  wire logic [mldq_pkg::IN_TUSER_W-1:0]    s_axis_tuser_i,
  output logic                                    m_axis_tvalid_o,
  input  wire logic                               m_axis_tready_i,
  // entry_index[3:0], entry_level[5:4], buffer_offset[16:6],
  // entry_length[28:17], stream_offset[60:29], zero pad
  output logic [mldq_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // status[1:0], found[2]
  output logic [mldq_pkg::OUT_TUSER_W-1:0]        m_axis_tuser_o
);
  import mldq_pkg::*;

  state_e state_q, state_d;

  logic [KIND_W-1:0] kind_q, kind_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [REF_W-1:0]  ref_q, ref_d;

  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [LINK_W-1:0] head_q [LEVELS];
  logic [LINK_W-1:0] head_d [LEVELS];
  logic [LINK_W-1:0] tail_q [LEVELS];
  logic [LINK_W-1:0] tail_d [LEVELS];
  logic [SOFS_W-1:0] lso_q [LEVELS];
  logic [SOFS_W-1:0] lso_d [LEVELS];

  logic [LINK_W-1:0] cur_head_q, cur_head_d;
  logic [LINK_W-1:0] cur_tail_q, cur_tail_d;
  logic [SOFS_W-1:0] cur_lso_q, cur_lso_d;
  logic [IDX_W-1:0]  app_idx_q, app_idx_d;
  logic [IDX_W-1:0]  link_tgt_q, link_tgt_d;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic              out_found_q, out_found_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  desc_t             out_desc_q, out_desc_d;

  link_req_t         link_req;
  desc_req_t         desc_req;
  logic [LINK_W-1:0] link_rd;
  desc_t             desc_rd;

  logic [LVL_W-1:0]  s_lvl;
  logic [LEN_W-1:0]  s_len;
  logic [REF_W-1:0]  s_ref;
  logic [SUM_W-1:0]  aligned;
  logic              len_ok;
  logic              fits;
  logic              ref_ok;
  logic              out_free;
  desc_t             new_desc;

  assign s_lvl = s_axis_tdata_i[LVL_W-1:0];
  assign s_len = s_axis_tdata_i[LVL_W +: LEN_W];
  assign s_ref = s_axis_tdata_i[LVL_W+LEN_W +: REF_W];

  assign aligned  = (SUM_W'(len_q) + SUM_W'(ALLOC_ALIGN - 1)) & ~SUM_W'(ALLOC_ALIGN - 1);
  assign len_ok   = SUM_W'(len_q) <= SUM_W'(BUFFER_BYTES);
  assign fits     = (SUM_W'(fill_q) + aligned) <= SUM_W'(BUFFER_BYTES);
  assign ref_ok   = int'(ref_q) < DESC_COUNT;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign new_desc = '{level: lvl_q, pos: OFS_W'(fill_q), length: len_q, stream: cur_lso_q};

  mldq_link_mem u_link_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (link_req),
    .rdata_o (link_rd)
  );

  mldq_desc_mem u_desc_mem (
    .clk_i   (clk_i),
    .req_i   (desc_req),
    .rdata_o (desc_rd)
  );

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    lvl_d        = lvl_q;
    len_d        = len_q;
    ref_d        = ref_q;
    free_head_d  = free_head_q;
    fill_d       = fill_q;
    head_d       = head_q;
    tail_d       = tail_q;
    lso_d        = lso_q;
    cur_head_d   = cur_head_q;
    cur_tail_d   = cur_tail_q;
    cur_lso_d    = cur_lso_q;
    app_idx_d    = app_idx_q;
    link_tgt_d   = link_tgt_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_found_d  = out_found_q;
    out_idx_d    = out_idx_q;
    out_desc_d   = out_desc_q;
    link_req     = '0;
    desc_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d     = s_axis_tuser_i;
          lvl_d      = s_lvl;
          len_d      = s_len;
          ref_d      = s_ref;
          cur_head_d = head_q[s_lvl];
          cur_tail_d = tail_q[s_lvl];
          cur_lso_d  = lso_q[s_lvl];
          link_req.re    = 1'b1;
          link_req.raddr = (s_axis_tuser_i == K_FOLLOW) ? IDX_W'(s_ref) :
                           (s_axis_tuser_i == K_APPEND) ? free_head_q[IDX_W-1:0] :
                                                          head_q[s_lvl][IDX_W-1:0];
          desc_req.re    = 1'b1;
          desc_req.raddr = head_q[s_lvl][IDX_W-1:0];
          state_d    = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_found_d  = 1'b0;
          out_idx_d    = '0;
          out_desc_d   = '0;
          state_d      = S_IDLE;
          case (kind_q)
            K_APPEND: begin
              if (!len_ok) begin
                out_status_d = ST_TOO_LARGE;
              end else if (!is_link(free_head_q)) begin
                out_status_d = ST_NO_DESC;
              end else if (!fits) begin
                out_status_d = ST_NO_SPACE;
              end else begin
                out_found_d    = 1'b1;
                out_idx_d      = free_head_q[IDX_W-1:0];
                out_desc_d     = new_desc;
                desc_req.we    = 1'b1;
                desc_req.waddr = free_head_q[IDX_W-1:0];
                desc_req.wdata = new_desc;
                link_req.we    = 1'b1;
                link_req.waddr = free_head_q[IDX_W-1:0];
                link_req.wdata = LINK_NULL;
                free_head_d    = link_rd;
                fill_d         = fill_q + FILL_W'(aligned);
                lso_d[lvl_q]   = cur_lso_q + SOFS_W'(len_q);
                tail_d[lvl_q]  = free_head_q;
                if (is_link(cur_tail_q)) begin
                  app_idx_d  = free_head_q[IDX_W-1:0];
                  link_tgt_d = cur_tail_q[IDX_W-1:0];
                  state_d    = S_LINK;
                end else begin
                  head_d[lvl_q] = free_head_q;
                end
              end
            end
            K_PEEK: begin
              if (is_link(cur_head_q)) begin
                out_found_d = 1'b1;
                out_idx_d   = cur_head_q[IDX_W-1:0];
                out_desc_d  = desc_rd;
              end
            end
            K_FOLLOW: begin
              if (ref_ok && is_link(link_rd)) begin
                out_valid_d    = out_valid_q && !m_axis_tready_i;
                desc_req.re    = 1'b1;
                desc_req.raddr = link_rd[IDX_W-1:0];
                out_idx_d      = link_rd[IDX_W-1:0];
                state_d        = S_FOLLOW;
              end
            end
            K_POP: begin
              if (is_link(cur_head_q)) begin
                out_found_d   = 1'b1;
                out_idx_d     = cur_head_q[IDX_W-1:0];
                out_desc_d    = desc_rd;
                head_d[lvl_q] = link_rd;
                if (!is_link(link_rd)) begin
                  tail_d[lvl_q] = LINK_NULL;
                end
              end
            end
            K_CLEAR: begin
              head_d[lvl_q] = LINK_NULL;
              tail_d[lvl_q] = LINK_NULL;
            end
            default: begin
            end
          endcase
        end
      end

      S_FOLLOW: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_found_d  = 1'b1;
          out_desc_d   = desc_rd;
          state_d      = S_IDLE;
        end
      end

      S_LINK: begin
        link_req.we    = 1'b1;
        link_req.waddr = link_tgt_q;
        link_req.wdata = LINK_W'(app_idx_q);
        state_d        = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= LINK_NULL;
        tail_q[i] <= LINK_NULL;
        lso_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      lso_q       <= lso_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    lvl_q        <= lvl_d;
    len_q        <= len_d;
    ref_q        <= ref_d;
    cur_head_q   <= cur_head_d;
    cur_tail_q   <= cur_tail_d;
    cur_lso_q    <= cur_lso_d;
    app_idx_q    <= app_idx_d;
    link_tgt_q   <= link_tgt_d;
    out_status_q <= out_status_d;
    out_found_q  <= out_found_d;
    out_idx_q    <= out_idx_d;
    out_desc_q   <= out_desc_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = {out_found_q, out_status_q};
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_desc_q.stream, out_desc_q.length,
                            out_desc_q.pos, out_desc_q.level, EIDX_W'(out_idx_q)};

endmodule

`default_nettype wire

// File: src/mldq_link_mem.sv
// link table: synchronous memory, one read and one write port, per-entry valid bits
// an entry never written reads as its reset link; depends on mldq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mldq_link_mem (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mldq_pkg::link_req_t req_i,
  output logic [mldq_pkg::LINK_W-1:0] rdata_o
);
  import mldq_pkg::*;

  logic [LINK_W-1:0] mem [DESC_COUNT];
  logic [DESC_COUNT-1:0] vld_q;
  logic [LINK_W-1:0] mem_rd_q;
  logic              vld_rd_q;
  logic [IDX_W-1:0]  raddr_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      mem_rd_q <= mem[req_i.raddr];
      raddr_q  <= req_i.raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        vld_rd_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = vld_rd_q ? mem_rd_q : link_reset(raddr_q);

endmodule

`default_nettype wire

// File: src/mldq_desc_mem.sv
// descriptor store: level, buffer position, length and stream offset
// synchronous memory, one read and one write port, read data registered; depends on mldq_pkg
`timescale 1ns / 1ps
`default_nettype none

module mldq_desc_mem (
  input  wire logic                clk_i,
  input  wire mldq_pkg::desc_req_t req_i,
  output mldq_pkg::desc_t          rdata_o
);
  import mldq_pkg::*;

  desc_t mem [DESC_COUNT];
  desc_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire
